// ===== rtl/name_value_line_parser_core_assert.svh =====
// Assertion macros for the name/value line parser.
// Used by name_value_line_parser_core; needs aclk and aresetn in scope.
`ifndef NAME_VALUE_LINE_PARSER_CORE_ASSERT_SVH
`define NAME_VALUE_LINE_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked every edge outside reset
`define NVLP_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked every edge outside reset
`define NVLP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/nvlp_pkg.sv =====
// Shared constants, result record type and helpers for the line parser.
// No dependencies.
package nvlp_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] NAME_LIMIT_RST  = 16'h00FF;
    localparam logic [CFG_W-1:0] VALUE_LIMIT_RST = 16'h07FF;
    localparam logic [CNT_W-1:0] CNT_MAX         = 16'hFFFF;

    // register indexes
    localparam logic REG_NAME_LIMIT  = 1'b0;
    localparam logic REG_VALUE_LIMIT = 1'b1;

    // input modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_EOF  = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] K_NAME       = 3'd0;
    localparam logic [KIND_W-1:0] K_VALUE      = 3'd1;
    localparam logic [KIND_W-1:0] K_DONE       = 3'd2;
    localparam logic [KIND_W-1:0] K_DROP       = 3'd3;
    localparam logic [KIND_W-1:0] K_NAME_LONG  = 3'd4;
    localparam logic [KIND_W-1:0] K_VALUE_LONG = 3'd5;
    localparam logic [KIND_W-1:0] K_ABRUPT     = 3'd6;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data;
        logic              last;
    } res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ===== rtl/name_value_line_parser_core.sv =====
// Latency: a result reaching an empty queue is offered on m_ the cycle after
// its input. Throughput: one input byte per cycle while m_tready is high and
// each byte gives at most one result; a byte giving two results takes two
// entries of a four-entry result queue, and s_tready needs two free entries.
// Reset (aresetn, synchronous, active low): line start, counts and held byte
// zero, limits 255 and 2047, queue empty. Errors halt parsing until reset.
`include "name_value_line_parser_core_assert.svh"

module name_value_line_parser_core
    import nvlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte[7:0]
    input  logic              s_tuser,   // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte[7:0]
    output logic [KIND_W-1:0] m_tuser,   // kind[2:0]
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_LINE_START, ST_COMMENT, ST_FIND_NAME, ST_COLLECT_NAME,
        ST_FIND_VALUE, ST_COLLECT_VALUE, ST_CONTINUE_VALUE, ST_HALTED
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     name_cnt_reg, name_cnt_next;
    logic [CNT_W-1:0]     value_cnt_reg, value_cnt_next;
    logic [7:0]           held_reg, held_next;
    logic [CFG_W-1:0]     name_limit_reg, value_limit_reg;

    res_t                 q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]      q_cnt_reg;

    res_t                 r0, r1;
    logic [1:0]           n_res;
    logic                 in_acc, out_acc;
    logic [QPTR_W-1:0]    wr_ptr_p1;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign s_tready  = (q_cnt_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign m_tvalid  = (q_cnt_reg != '0);
    assign m_tdata   = q_reg[rd_ptr_reg].data;
    assign m_tuser   = q_reg[rd_ptr_reg].kind;
    assign m_tlast   = q_reg[rd_ptr_reg].last;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // one parse step per accepted byte
    always_comb begin
        state_next     = state_reg;
        name_cnt_next  = name_cnt_reg;
        value_cnt_next = value_cnt_reg;
        held_next      = held_reg;
        r0             = '0;
        r1             = '0;
        n_res          = 2'd0;
        if (state_reg != ST_HALTED) begin
            if (s_tuser == MODE_EOF) begin
                if (state_reg != ST_LINE_START) begin
                    r0         = '{kind: K_ABRUPT, data: 8'h00, last: 1'b1};
                    n_res      = 2'd1;
                    state_next = ST_HALTED;
                end
            end else if (name_cnt_reg >= name_limit_reg) begin
                r0         = '{kind: K_NAME_LONG, data: 8'h00, last: 1'b1};
                n_res      = 2'd1;
                state_next = ST_HALTED;
            end else if (value_cnt_reg >= value_limit_reg) begin
                r0         = '{kind: K_VALUE_LONG, data: 8'h00, last: 1'b1};
                n_res      = 2'd1;
                state_next = ST_HALTED;
            end else begin
                case (state_reg)
                    ST_LINE_START: begin
                        name_cnt_next  = '0;
                        value_cnt_next = '0;
                        if (s_tdata == CH_HASH) begin
                            state_next = ST_COMMENT;
                        end else if (s_tdata == CH_LF) begin
                            state_next = ST_LINE_START;
                        end else if (is_blank(s_tdata)) begin
                            state_next = ST_FIND_NAME;
                        end else begin
                            state_next    = ST_COLLECT_NAME;
                            name_cnt_next = {{(CNT_W-1){1'b0}}, 1'b1};
                            r0            = '{kind: K_NAME, data: s_tdata, last: 1'b1};
                            n_res         = 2'd1;
                        end
                    end
                    ST_COMMENT: begin
                        if (s_tdata == CH_LF) begin
                            state_next = ST_LINE_START;
                        end
                    end
                    ST_FIND_NAME: begin
                        if (s_tdata == CH_LF) begin
                            state_next = ST_LINE_START;
                        end else if (!is_blank(s_tdata)) begin
                            state_next    = ST_COLLECT_NAME;
                            name_cnt_next = bump(name_cnt_reg);
                            r0            = '{kind: K_NAME, data: s_tdata, last: 1'b1};
                            n_res         = 2'd1;
                        end
                    end
                    ST_COLLECT_NAME: begin
                        if (s_tdata == CH_LF) begin
                            r0         = '{kind: K_DROP, data: 8'h00, last: 1'b1};
                            n_res      = 2'd1;
                            state_next = ST_LINE_START;
                        end else if (is_blank(s_tdata)) begin
                            state_next = ST_FIND_VALUE;
                        end else begin
                            name_cnt_next = bump(name_cnt_reg);
                            r0            = '{kind: K_NAME, data: s_tdata, last: 1'b1};
                            n_res         = 2'd1;
                        end
                    end
                    ST_FIND_VALUE, ST_CONTINUE_VALUE: begin
                        if (s_tdata == CH_LF) begin
                            r0         = '{kind: K_DONE, data: 8'h00, last: 1'b1};
                            n_res      = 2'd1;
                            state_next = ST_LINE_START;
                        end else if (!is_blank(s_tdata)) begin
                            state_next     = ST_COLLECT_VALUE;
                            value_cnt_next = bump(value_cnt_reg);
                            held_next      = s_tdata;
                        end
                    end
                    ST_COLLECT_VALUE: begin
                        if (s_tdata == CH_LF) begin
                            if (held_reg == CH_BSL) begin
                                // line continuation: backslash becomes CR
                                r0         = '{kind: K_VALUE, data: CH_CR, last: 1'b1};
                                n_res      = 2'd1;
                                state_next = ST_CONTINUE_VALUE;
                            end else begin
                                r0         = '{kind: K_VALUE, data: held_reg, last: 1'b0};
                                r1         = '{kind: K_DONE, data: 8'h00, last: 1'b1};
                                n_res      = 2'd2;
                                state_next = ST_LINE_START;
                            end
                        end else begin
                            r0             = '{kind: K_VALUE, data: held_reg, last: 1'b1};
                            n_res          = 2'd1;
                            value_cnt_next = bump(value_cnt_reg);
                            held_next      = s_tdata;
                        end
                    end
                    default: begin
                        state_next = ST_HALTED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LINE_START;
            name_cnt_reg    <= '0;
            value_cnt_reg   <= '0;
            held_reg        <= '0;
            name_limit_reg  <= NAME_LIMIT_RST;
            value_limit_reg <= VALUE_LIMIT_RST;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            q_cnt_reg       <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_NAME_LIMIT) begin
                    name_limit_reg <= cfg_wdata;
                end else begin
                    value_limit_reg <= cfg_wdata;
                end
            end
            if (in_acc) begin
                state_reg     <= state_next;
                name_cnt_reg  <= name_cnt_next;
                value_cnt_reg <= value_cnt_next;
                held_reg      <= held_next;
                wr_ptr_reg    <= wr_ptr_reg + QPTR_W'(n_res);
            end
            if (out_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + (in_acc ? (QPTR_W+1)'(n_res) : '0)
                         - (QPTR_W+1)'(out_acc);
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (in_acc && n_res != 2'd0) begin
            q_reg[wr_ptr_reg] <= r0;
        end
        if (in_acc && n_res == 2'd2) begin
            q_reg[wr_ptr_p1] <= r1;
        end
    end

    `NVLP_ASSERT_NOW(a_queue_bound, 1'b1, q_cnt_reg <= (QPTR_W+1)'(QUEUE_DEPTH),
        "result queue overflow")
    `NVLP_ASSERT_NEXT(a_halt_sticky, state_reg == ST_HALTED, state_reg == ST_HALTED,
        "parser left halted state")
    `NVLP_ASSERT_NEXT(a_eof_line_start,
        in_acc && s_tuser == MODE_EOF && state_reg == ST_LINE_START,
        state_reg == ST_LINE_START && q_cnt_reg <= $past(q_cnt_reg),
        "end of file at line start changed state or produced a result")

endmodule

// ===== sim/nvlp_token_checker.sv =====
// Result checker for name_value_line_parser_core: follows input and register
// traffic, predicts the parser output tokens and compares every result transaction.
// Depends on nvlp_pkg.
module nvlp_token_checker
    import nvlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte[7:0]
    input  logic              s_tuser,   // mode
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // out_byte[7:0]
    input  logic [KIND_W-1:0] m_tuser,   // kind[2:0]
    input  logic              m_tlast,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int unsigned       mismatches,
    output int unsigned       tokens_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PS_LINE_START,
        PS_COMMENT,
        PS_FIND_NAME,
        PS_COLLECT_NAME,
        PS_FIND_VALUE,
        PS_COLLECT_VALUE,
        PS_CONTINUE_VALUE,
        PS_HALTED
    } parse_state_t;

    parse_state_t     pstate;
    logic [CNT_W-1:0] name_cnt;
    logic [CNT_W-1:0] value_cnt;
    logic [7:0]       held;
    logic [CFG_W-1:0] name_lim;
    logic [CFG_W-1:0] value_lim;

    res_t        tokens_q[$];
    res_t        step_out[2];
    int          step_n;
    res_t        want;
    int unsigned fail_cnt = 0;

    function automatic bit is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic emit_token(input logic [KIND_W-1:0] k, input logic [7:0] b);
        step_out[step_n] = {k, b, 1'b0};
        step_n++;
    endtask

    // One input transaction: update parser state, queue the tokens it causes.
    task automatic parse_byte(input logic mode, input logic [7:0] c);
        res_t tok;
        step_n = 0;
        if (pstate == PS_HALTED) begin
            // dead until reset
        end else if (mode == MODE_EOF) begin
            if (pstate != PS_LINE_START) begin
                emit_token(K_ABRUPT, 8'h00);
                pstate = PS_HALTED;
            end
        end else if (name_cnt >= name_lim) begin
            emit_token(K_NAME_LONG, 8'h00);
            pstate = PS_HALTED;
        end else if (value_cnt >= value_lim) begin
            emit_token(K_VALUE_LONG, 8'h00);
            pstate = PS_HALTED;
        end else begin
            case (pstate)
                PS_LINE_START: begin
                    name_cnt  = '0;
                    value_cnt = '0;
                    if (c == CH_HASH) begin
                        pstate = PS_COMMENT;
                    end else if (c != CH_LF) begin
                        if (is_ws(c)) begin
                            pstate = PS_FIND_NAME;
                        end else begin
                            pstate   = PS_COLLECT_NAME;
                            name_cnt = count_up(name_cnt);
                            emit_token(K_NAME, c);
                        end
                    end
                end
                PS_COMMENT: begin
                    if (c == CH_LF) pstate = PS_LINE_START;
                end
                PS_FIND_NAME: begin
                    if (c == CH_LF) begin
                        pstate = PS_LINE_START;
                    end else if (!is_ws(c)) begin
                        pstate   = PS_COLLECT_NAME;
                        name_cnt = count_up(name_cnt);
                        emit_token(K_NAME, c);
                    end
                end
                PS_COLLECT_NAME: begin
                    if (c == CH_LF) begin
                        emit_token(K_DROP, 8'h00);
                        pstate = PS_LINE_START;
                    end else if (is_ws(c)) begin
                        pstate = PS_FIND_VALUE;
                    end else begin
                        name_cnt = count_up(name_cnt);
                        emit_token(K_NAME, c);
                    end
                end
                PS_FIND_VALUE, PS_CONTINUE_VALUE: begin
                    if (c == CH_LF) begin
                        emit_token(K_DONE, 8'h00);
                        pstate = PS_LINE_START;
                    end else if (!is_ws(c)) begin
                        pstate    = PS_COLLECT_VALUE;
                        value_cnt = count_up(value_cnt);
                        held      = c;
                    end
                end
                PS_COLLECT_VALUE: begin
                    // value bytes go out one transaction late
                    if (c == CH_LF) begin
                        if (held == CH_BSL) begin
                            emit_token(K_VALUE, CH_CR);
                            pstate = PS_CONTINUE_VALUE;
                        end else begin
                            emit_token(K_VALUE, held);
                            emit_token(K_DONE, 8'h00);
                            pstate = PS_LINE_START;
                        end
                    end else begin
                        emit_token(K_VALUE, held);
                        value_cnt = count_up(value_cnt);
                        held      = c;
                    end
                end
                default: ;
            endcase
        end
        for (int i = 0; i < step_n; i++) begin
            tok      = step_out[i];
            tok.last = (i == step_n - 1);
            tokens_q.push_back(tok);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pstate    = PS_LINE_START;
            name_cnt  = '0;
            value_cnt = '0;
            held      = '0;
            name_lim  = NAME_LIMIT_RST;
            value_lim = VALUE_LIMIT_RST;
            tokens_q.delete();
        end else begin
            // output side first, so a stray result never consumes a fresh token
            if (m_tvalid && m_tready) begin
                if (tokens_q.size() == 0) begin
                    $error("unexpected result: kind %0d, out_byte %02h, last %0b",
                           m_tuser, m_tdata, m_tlast);
                    fail_cnt++;
                end else begin
                    want = tokens_q.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_addr == REG_NAME_LIMIT) name_lim = cfg_wdata;
                else value_lim = cfg_wdata;
            end
            if (s_tvalid && s_tready) parse_byte(s_tuser, s_tdata);
        end
        mismatches     <= fail_cnt;
        tokens_pending <= tokens_q.size();
    end

endmodule

// ===== sim/name_value_line_parser_core_tb.sv =====
// Top testbench for name_value_line_parser_core: clock, reset, text stimulus,
// limit register writes and the verdict. Checking lives in nvlp_token_checker.
// Depends on nvlp_pkg, name_value_line_parser_core and nvlp_token_checker.
module name_value_line_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nvlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef enum {
        FAULT_STALE_NAME,
        FAULT_LONG_VALUE,
        FAULT_LONG_NAME,
        FAULT_CUT_LINE
    } fault_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // data_byte[7:0]
    logic              s_tuser;   // mode
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // out_byte[7:0]
    logic [KIND_W-1:0] m_tuser;   // kind[2:0]
    logic              m_tlast;
    logic              cfg_we;
    logic              cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    int unsigned mismatches;
    int unsigned tokens_pending;
    int unsigned cycle_cnt = 0;
    int unsigned tx_count  = 0;
    int unsigned rx_count  = 0;
    bit          tx_calm;
    bit          rx_calm;
    int unsigned lim_name  = 32'(NAME_LIMIT_RST);
    int unsigned lim_value = 32'(VALUE_LIMIT_RST);

    name_value_line_parser_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    nvlp_token_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .tokens_pending (tokens_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side back-pressure; calm stretches keep tready high throughout.
    initial begin
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            rx_count++;
            gap = rx_calm ? 0 : $urandom_range(0, 16);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_byte(input logic mode, input logic [7:0] b);
        int unsigned gap;
        if (tx_count % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        tx_count++;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(MODE_BYTE, txt[i]);
    endtask

    // Wait for every predicted token, then for byte-only work still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tokens_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] nl, input logic [CFG_W-1:0] vl);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_NAME_LIMIT;
        cfg_wdata <= nl;
        @(posedge aclk);
        cfg_addr  <= REG_VALUE_LIMIT;
        cfg_wdata <= vl;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        lim_name  = 32'(nl);
        lim_value = 32'(vl);
    endtask

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] solid_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_SP || (b >= CH_TAB && b <= CH_CR));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(9, 13)); while (b == CH_LF);
        if ($urandom_range(0, 1) == 1) b = CH_SP;
        return b;
    endfunction

    // Well-formed record: optional indent, name, then drop, empty value or a
    // value split over continuation lines. Lengths stay under the limits.
    task automatic send_record(input int unsigned name_max, input int unsigned value_max);
        int unsigned lead, nlen, vtot, chunks, left, clen, shape;
        bit          tail;
        logic [7:0]  b;
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (lead) send_byte(MODE_BYTE, blank_byte());
        nlen = $urandom_range(1, name_max);
        for (int i = 0; i < nlen; i++) begin
            b = solid_byte();
            if (i == 0 && lead == 0 && b == CH_HASH) b = "N";
            send_byte(MODE_BYTE, b);
        end
        shape = $urandom_range(0, 7);
        if (shape == 0) begin
            send_byte(MODE_BYTE, CH_LF);
        end else if (shape == 1 || value_max == 0) begin
            repeat ($urandom_range(1, 2)) send_byte(MODE_BYTE, blank_byte());
            send_byte(MODE_BYTE, CH_LF);
        end else begin
            repeat ($urandom_range(1, 2)) send_byte(MODE_BYTE, blank_byte());
            vtot = $urandom_range(1, value_max);
            // trailing backslash then an empty or blank line ends the record too
            tail = (vtot > 1) && ($urandom_range(0, 5) == 0);
            if (tail) vtot--;
            chunks = $urandom_range(1, (vtot > 3) ? 3 : vtot);
            left   = vtot;
            for (int k = 0; k < chunks; k++) begin
                clen = (k == chunks - 1) ? left : $urandom_range(1, left - (chunks - 1 - k));
                left -= clen;
                for (int i = 0; i < clen; i++) begin
                    b = (i == 0) ? solid_byte() : any_but_lf();
                    if (i == clen - 1) begin
                        if (k != chunks - 1) b = CH_BSL;
                        else if (b == CH_BSL) b = "v";
                    end
                    send_byte(MODE_BYTE, b);
                end
                if (k != chunks - 1) begin
                    send_byte(MODE_BYTE, CH_LF);
                    repeat ($urandom_range(0, 2)) send_byte(MODE_BYTE, blank_byte());
                end
            end
            if (tail) begin
                send_byte(MODE_BYTE, CH_BSL);
                send_byte(MODE_BYTE, CH_LF);
                repeat ($urandom_range(0, 2)) send_byte(MODE_BYTE, blank_byte());
            end
            send_byte(MODE_BYTE, CH_LF);
        end
    endtask

    // One line of some sort; always ends back at line start.
    task automatic send_random_line();
        int unsigned pick, nmax, vmax;
        nmax = (lim_name - 1 > 10) ? 10 : lim_name - 1;
        vmax = (lim_value - 1 > 16) ? 16 : lim_value - 1;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_record(nmax, vmax);
        end else if (pick < 65) begin
            send_byte(MODE_BYTE, CH_HASH);
            repeat ($urandom_range(0, 8)) send_byte(MODE_BYTE, any_but_lf());
            send_byte(MODE_BYTE, CH_LF);
        end else if (pick < 71) begin
            send_byte(MODE_BYTE, CH_LF);
        end else if (pick < 76) begin
            repeat ($urandom_range(1, 3)) send_byte(MODE_BYTE, blank_byte());
            send_byte(MODE_BYTE, CH_LF);
        end else if (pick < 82) begin
            send_byte(MODE_EOF, 8'($urandom_range(0, 255)));
        end else begin
            // garbage, then "z\n" which lands at line start from any state
            repeat ($urandom_range(0, ((nmax < vmax) ? nmax : vmax) - 1))
                send_byte(MODE_BYTE, any_but_lf());
            send_text("z\n");
        end
    endtask

    task automatic random_lines(input int unsigned count);
        int unsigned stop_at;
        stop_at = tx_count + count;
        while (tx_count < stop_at) send_random_line();
    endtask

    initial begin
        fault_t fault;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_BYTE;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_NAME_LIMIT;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty line, comment, blank line, continuation, drop, name without value
        send_text("\n#x\n \t\n");
        send_text("a b\\\n c\n");
        send_text("n\nm \n");
        send_byte(MODE_EOF, 8'hFF);
        send_byte(MODE_BYTE, 8'hFF);
        send_byte(MODE_BYTE, CH_SP);
        send_byte(MODE_BYTE, 8'h00);
        send_byte(MODE_BYTE, CH_LF);

        random_lines(100);

        set_limits(16'd2, 16'd2);
        random_lines(50);

        // widest limits with a name beyond the reset name limit
        set_limits(16'hFFFF, 16'hFFFF);
        send_byte(MODE_BYTE, "L");
        repeat (259) send_byte(MODE_BYTE, solid_byte());
        send_byte(MODE_BYTE, CH_SP);
        repeat (99) send_byte(MODE_BYTE, solid_byte());
        send_byte(MODE_BYTE, CH_LF);
        send_text("z\n");
        random_lines(40);

        repeat (3) begin
            set_limits(16'($urandom_range(2, 24)), 16'($urandom_range(2, 40)));
            random_lines(50);
        end

        // one halting error per run, then traffic that must stay silent
        fault = fault_t'($urandom_range(0, 3));
        case (fault)
            FAULT_STALE_NAME: begin
                send_text("abcd ef\n");
                set_limits(16'($urandom_range(0, 4)), 16'hFFFF);
                send_text("q");
            end
            FAULT_LONG_VALUE: begin
                set_limits(16'hFFFF, 16'($urandom_range(1, 3)));
                send_text("k vvvvv\n");
            end
            FAULT_LONG_NAME: begin
                set_limits(16'($urandom_range(1, 3)), 16'hFFFF);
                send_text("nnnnnn x\n");
            end
            default: begin
                send_text("nm v");
                send_byte(MODE_EOF, 8'($urandom_range(0, 255)));
            end
        endcase
        repeat (12) send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        settle();
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
